/* src/isp_pkg.sv */
package isp_pkg;

	localparam int unsigned LANES  = 8;
	localparam int unsigned PIX_W  = 8;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned RANK_W = $clog2(LANES);

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(LANES);
	localparam logic [CNT_W-1:0] CNT_MIN   = CNT_W'(1);

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [RANK_W-1:0] rank_t;

	typedef pix_t [LANES-1:0] pix_arr_t;

	// per-lane outcome of the ranking stage
	typedef struct packed {
		logic  used;
		rank_t rank;
	} lane_res_t;

	typedef lane_res_t [LANES-1:0] lane_res_arr_t;

	// what the merging stage needs to know about the count
	typedef struct packed {
		rank_t half;
		logic  odd;
	} merge_ctrl_t;

endpackage

/* src/isp_ifs.sv */
interface isp_sample_if;
	logic           valid;
	logic           ready;
	isp_pkg::pix_t  sample_0;
	isp_pkg::pix_t  sample_1;
	isp_pkg::pix_t  sample_2;
	isp_pkg::pix_t  sample_3;
	isp_pkg::pix_t  sample_4;
	isp_pkg::pix_t  sample_5;
	isp_pkg::pix_t  sample_6;
	isp_pkg::pix_t  sample_7;

	modport source (output valid, output sample_0, output sample_1, output sample_2,
		output sample_3, output sample_4, output sample_5, output sample_6,
		output sample_7, input ready);
	modport sink (input valid, input sample_0, input sample_1, input sample_2,
		input sample_3, input sample_4, input sample_5, input sample_6,
		input sample_7, output ready);
endinterface

interface isp_result_if;
	logic          valid;
	logic          ready;
	isp_pkg::pix_t median_value;

	modport source (output valid, output median_value, input ready);
	modport sink (input valid, input median_value, output ready);
endinterface

/* src/isp_lane.sv */
module isp_lane #(
	parameter int unsigned LANE_IDX = 0
) (
	input  isp_pkg::pix_arr_t  samples,
	input  isp_pkg::cnt_t      count,
	output isp_pkg::lane_res_t res
);

	localparam isp_pkg::cnt_t MY_IDX = isp_pkg::CNT_W'(LANE_IDX);

	logic [isp_pkg::LANES-1:0] below;
	isp_pkg::pix_t             mine;

	assign mine = samples[LANE_IDX];

	// stable rank: equal samples are ordered by lane number
	always_comb begin
		for (int j = 0; j < isp_pkg::LANES; j++) begin
			if (j == LANE_IDX) begin
				below[j] = 1'b0;
			end else begin
				below[j] = (isp_pkg::CNT_W'(j) < count) &&
					((samples[j] < mine) || ((samples[j] == mine) && (j < LANE_IDX)));
			end
		end
	end

	always_comb begin
		res.used = MY_IDX < count;
		res.rank = '0;
		for (int j = 0; j < isp_pkg::LANES; j++) begin
			res.rank = res.rank + isp_pkg::RANK_W'(below[j]);
		end
	end

endmodule

/* src/isp_merge.sv */
module isp_merge (
	input  isp_pkg::pix_arr_t      samples,
	input  isp_pkg::lane_res_arr_t lanes,
	input  isp_pkg::merge_ctrl_t   ctrl,
	output isp_pkg::pix_t          median
);

	isp_pkg::pix_t                hi;
	isp_pkg::pix_t                lo;
	isp_pkg::rank_t               half_lo;
	logic [isp_pkg::PIX_W:0]      pair_sum;

	assign half_lo = ctrl.half - isp_pkg::RANK_W'(1);

	// ranks are unique among used lanes, so at most one lane hits each
	always_comb begin
		hi = '0;
		lo = '0;
		for (int i = 0; i < isp_pkg::LANES; i++) begin
			if (lanes[i].used && (lanes[i].rank == ctrl.half)) begin
				hi = hi | samples[i];
			end
			if (lanes[i].used && (lanes[i].rank == half_lo)) begin
				lo = lo | samples[i];
			end
		end
	end

	assign pair_sum = {1'b0, hi} + {1'b0, lo};
	assign median   = ctrl.odd ? hi : pair_sum[isp_pkg::PIX_W:1];

endmodule

/* src/image_stack_pixel_median.sv */
// A transaction reaches result valid through the rank stage, then the merge stage.
// Throughput: one transaction per cycle when not stalled; each lane ranks its sample
// with LANES-1 comparators and a popcount; merge picks the middle sample or pair mean.
// Reset (arst_n low, asynchronous): pipeline emptied, count_q back to 8.
// Stalls on the result side back up through the two stage registers only.
module image_stack_pixel_median (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  isp_pkg::cnt_t        cfg_wdata,
	isp_sample_if.sink           samples,
	isp_result_if.source         result
);

	isp_pkg::cnt_t          count_q;
	isp_pkg::pix_arr_t      smp_in;
	isp_pkg::lane_res_arr_t lane_res;
	isp_pkg::merge_ctrl_t   ctrl_in;
	isp_pkg::pix_t          median_in;

	logic                   valid_s1;
	isp_pkg::pix_arr_t      smp_s1;
	isp_pkg::lane_res_arr_t lane_res_s1;
	isp_pkg::merge_ctrl_t   ctrl_s1;

	logic                   valid_s2;
	isp_pkg::pix_t          median_s2;

	logic                   adv_s2;
	logic                   adv_s1;

	// count kept already clamped to 1..LANES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= isp_pkg::CNT_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				count_q <= isp_pkg::CNT_MIN;
			end else if (cfg_wdata > isp_pkg::CNT_RESET) begin
				count_q <= isp_pkg::CNT_RESET;
			end else begin
				count_q <= cfg_wdata;
			end
		end
	end

	assign smp_in[0] = samples.sample_0;
	assign smp_in[1] = samples.sample_1;
	assign smp_in[2] = samples.sample_2;
	assign smp_in[3] = samples.sample_3;
	assign smp_in[4] = samples.sample_4;
	assign smp_in[5] = samples.sample_5;
	assign smp_in[6] = samples.sample_6;
	assign smp_in[7] = samples.sample_7;

	assign ctrl_in.half = count_q[isp_pkg::CNT_W-1:1];
	assign ctrl_in.odd  = count_q[0];

	for (genvar g = 0; g < isp_pkg::LANES; g++) begin : g_lane
		isp_lane #(
			.LANE_IDX(g)
		) u_lane (
			.samples(smp_in),
			.count  (count_q),
			.res    (lane_res[g])
		);
	end

	assign adv_s2        = !valid_s2 || result.ready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign samples.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= samples.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && samples.valid) begin
			smp_s1      <= smp_in;
			lane_res_s1 <= lane_res;
			ctrl_s1     <= ctrl_in;
		end
		if (adv_s2 && valid_s1) begin
			median_s2 <= median_in;
		end
	end

	isp_merge u_merge (
		.samples(smp_s1),
		.lanes  (lane_res_s1),
		.ctrl   (ctrl_s1),
		.median (median_in)
	);

	assign result.valid        = valid_s2;
	assign result.median_value = median_s2;

endmodule

/* src/isp_checker.sv */
module isp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input isp_pkg::pix_t median_value
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_value))
		else $error("result changed while stalled");

	// every accepted transaction shows up as a valid result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("result missing two cycles after accept");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output stage empty");

	// nothing comes out of an empty pipe
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2) || $past(!in_ready, 1))
		else $error("result without earlier transaction");

endmodule

bind image_stack_pixel_median isp_checker u_isp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.median_value(result.median_value)
);
